FILE: rtl/core/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants for the length-prefixed stream deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

  localparam int unsigned LenW = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned HbW = 64;

  localparam logic [LenW-1:0] MAX_LEN_RST = 16'd4094;
  localparam logic [LenW-1:0] HB_LEN = 16'd8;

  typedef enum logic [1:0] {
    PH_LEN_LO  = 2'd0,
    PH_LEN_HI  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_CLOSED  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic [TimeW-1:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       packet_last;
    logic       is_heartbeat;
    logic       framing_error;
  } out_item_t;

endpackage

FILE: rtl/core/lpd_parse.sv
// ----------------------------------------------------------------------------
// lpd_parse
// Length prefix parser: tracks the packet phase and byte count, checks the
// length and detects heartbeat replies. Produces at most one result a request.
// ----------------------------------------------------------------------------
module lpd_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  input  logic                acc,
  input  lpd_pkg::in_item_t   item,
  output logic                res_valid,
  output lpd_pkg::out_item_t  res
);

  lpd_pkg::phase_t phase_r, phase_nxt;
  logic [lpd_pkg::LenW-1:0]  max_len_r;
  logic [7:0]                len_lo_r;
  logic [lpd_pkg::LenW-1:0]  bytes_left_r;
  logic                      len_is8_r;
  logic [lpd_pkg::HbW-1:0]   hb_r;
  logic [lpd_pkg::TimeW:0]   act_plus1_r;

  logic [lpd_pkg::LenW-1:0]  len;
  logic                      len_bad;
  logic                      pay_last;
  logic [lpd_pkg::HbW-1:0]   hb_word;
  logic                      hb_hit;

  assign len      = {item.data_byte, len_lo_r};
  assign len_bad  = (len == '0) || (len > max_len_r);
  assign pay_last = (bytes_left_r == {{(lpd_pkg::LenW-1){1'b0}}, 1'b1});
  // Bytes shift in from the top, so after eight of them the word is little-endian.
  assign hb_word  = {item.data_byte, hb_r[lpd_pkg::HbW-1:8]};
  assign hb_hit   = len_is8_r &&
                    (hb_word == {{(lpd_pkg::HbW-lpd_pkg::TimeW-1){1'b0}}, act_plus1_r});

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      lpd_pkg::PH_LEN_LO:  phase_nxt = lpd_pkg::PH_LEN_HI;
      lpd_pkg::PH_LEN_HI:  phase_nxt = len_bad ? lpd_pkg::PH_CLOSED : lpd_pkg::PH_PAYLOAD;
      lpd_pkg::PH_PAYLOAD: phase_nxt = pay_last ? lpd_pkg::PH_LEN_LO : lpd_pkg::PH_PAYLOAD;
      lpd_pkg::PH_CLOSED:  phase_nxt = lpd_pkg::PH_CLOSED;
      default:             phase_nxt = lpd_pkg::PH_CLOSED;
    endcase
  end

  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    case (phase_r)
      lpd_pkg::PH_LEN_HI: begin
        res_valid         = acc && len_bad;
        res.framing_error = 1'b1;
      end
      lpd_pkg::PH_PAYLOAD: begin
        res_valid        = acc;
        res.payload_byte = item.data_byte;
        res.packet_last  = pay_last;
        res.is_heartbeat = pay_last && hb_hit;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= lpd_pkg::PH_LEN_LO;
      max_len_r    <= lpd_pkg::MAX_LEN_RST;
      act_plus1_r  <= {{lpd_pkg::TimeW{1'b0}}, 1'b1};
      bytes_left_r <= '0;
      len_is8_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_len_r <= cfg_wdata;
      end
      if (acc) begin
        phase_r <= phase_nxt;
        if (phase_r == lpd_pkg::PH_LEN_HI) begin
          bytes_left_r <= len;
          len_is8_r    <= (len == lpd_pkg::HB_LEN);
        end
        if (phase_r == lpd_pkg::PH_PAYLOAD) begin
          bytes_left_r <= bytes_left_r - {{(lpd_pkg::LenW-1){1'b0}}, 1'b1};
          if (pay_last) begin
            act_plus1_r <= {1'b0, item.now_seconds} + {{lpd_pkg::TimeW{1'b0}}, 1'b1};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      if (phase_r == lpd_pkg::PH_LEN_LO) begin
        len_lo_r <= item.data_byte;
      end
      if (phase_r == lpd_pkg::PH_PAYLOAD) begin
        hb_r <= hb_word;
      end
    end
  end

`ifndef SYNTHESIS
  a_err_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.framing_error) |=> (phase_r == lpd_pkg::PH_CLOSED))
    else $error("framing error did not close the session");

  a_closed_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == lpd_pkg::PH_CLOSED) |=> (phase_r == lpd_pkg::PH_CLOSED))
    else $error("closed session reopened without reset");

  a_last_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (phase_r == lpd_pkg::PH_PAYLOAD) && pay_last) |=>
      (phase_r == lpd_pkg::PH_LEN_LO))
    else $error("packet end did not return to the length prefix");

  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == lpd_pkg::PH_PAYLOAD) |-> (bytes_left_r != '0))
    else $error("payload phase with no bytes left");
`endif

endmodule

FILE: rtl/core/lpd_out_reg.sv
// ----------------------------------------------------------------------------
// lpd_out_reg
// Result register: holds one result until downstream takes it, while the
// parser may accept a new request in the same cycle the held one leaves.
// ----------------------------------------------------------------------------
module lpd_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  input  lpd_pkg::out_item_t  res,
  output logic                take_ok,
  output logic                out_valid,
  input  logic                out_ready,
  output lpd_pkg::out_item_t  out_data
);

  logic               valid_r;
  lpd_pkg::out_item_t data_r;

  assign take_ok   = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_valid) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      data_r <= res;
    end
  end

endmodule

FILE: rtl/core/length_prefix_deframer_heartbeat.sv
// An accepted payload byte or error request shows on out_ in the next cycle.
// Throughput: one stream byte per cycle; the single result register limits it only when
// downstream stalls.
// Reset (synchronous, rst_n low): expect a length prefix, limit 4094, last activity zero.
// ----------------------------------------------------------------------------
// length_prefix_deframer_heartbeat
// Deframes a byte stream with 16-bit little-endian length prefixes and flags
// heartbeat replies.
// ----------------------------------------------------------------------------
module length_prefix_deframer_heartbeat (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  lpd_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lpd_pkg::out_item_t  out_data
);

  logic               acc;
  logic               res_valid;
  lpd_pkg::out_item_t res;
  logic               take_ok;

  assign in_ready = take_ok;
  assign acc      = in_valid && take_ok;

  lpd_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .item      (in_data),
    .res_valid (res_valid),
    .res       (res)
  );

  lpd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .take_ok   (take_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the length-prefixed deframer. It drives whole
// packets, heartbeat replies and near misses under several limit settings
// and idling patterns. A model of the deframer predicts each result, and the
// session is closed by a bad length only at the very end.
// ----------------------------------------------------------------------------
module tb;

  typedef enum int unsigned {
    CLOSE_ZERO_LEN,
    CLOSE_OVER_LIMIT,
    CLOSE_ZERO_LIMIT
  } close_cause_t;

  class packet_tracker;
    logic [15:0]        max_len;
    lpd_pkg::phase_t    state;
    logic [7:0]         len_lo;
    logic [15:0]        pkt_len;
    logic [15:0]        remaining;
    logic [63:0]        hb_word;
    logic [31:0]        last_time;
    lpd_pkg::out_item_t due[$];
    int unsigned        mismatches;

    function new();
      max_len    = lpd_pkg::MAX_LEN_RST;
      state      = lpd_pkg::PH_LEN_LO;
      len_lo     = '0;
      pkt_len    = '0;
      remaining  = '0;
      hb_word    = '0;
      last_time  = '0;
      mismatches = 0;
    endfunction

    function void set_limit(logic [15:0] value);
      max_len = value;
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction

    function void take_byte(lpd_pkg::in_item_t req);
      logic [15:0]        len;
      logic [15:0]        pos;
      lpd_pkg::out_item_t res;
      res = '0;
      case (state)
        lpd_pkg::PH_LEN_LO: begin
          len_lo = req.data_byte;
          state  = lpd_pkg::PH_LEN_HI;
        end
        lpd_pkg::PH_LEN_HI: begin
          len = {req.data_byte, len_lo};
          if (len == 16'd0 || len > max_len) begin
            state             = lpd_pkg::PH_CLOSED;
            res.framing_error = 1'b1;
            due.push_back(res);
          end else begin
            pkt_len   = len;
            remaining = len;
            hb_word   = '0;
            state     = lpd_pkg::PH_PAYLOAD;
          end
        end
        lpd_pkg::PH_PAYLOAD: begin
          pos = pkt_len - remaining;
          // Only the first eight payload bytes make up the heartbeat word.
          if (pos < 16'd8) hb_word[8*pos[2:0] +: 8] = req.data_byte;
          remaining        = remaining - 16'd1;
          res.payload_byte = req.data_byte;
          if (remaining == 16'd0) begin
            res.packet_last  = 1'b1;
            res.is_heartbeat = (pkt_len == lpd_pkg::HB_LEN) &&
                               (hb_word == {32'd0, last_time} + 64'd1);
            last_time        = req.now_seconds;
            state            = lpd_pkg::PH_LEN_LO;
          end
          due.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function void check_result(lpd_pkg::out_item_t got);
      lpd_pkg::out_item_t want;
      if (due.size() == 0) begin
        $error({"unexpected result: payload_byte %0h packet_last %0b",
                " is_heartbeat %0b framing_error %0b"},
               got.payload_byte, got.packet_last, got.is_heartbeat, got.framing_error);
        mismatches++;
        return;
      end
      want = due.pop_front();
      if (got.payload_byte !== want.payload_byte) begin
        $error("payload_byte: expected %0h, got %0h", want.payload_byte, got.payload_byte);
        mismatches++;
      end
      if (got.packet_last !== want.packet_last) begin
        $error("packet_last: expected %0b, got %0b", want.packet_last, got.packet_last);
        mismatches++;
      end
      if (got.is_heartbeat !== want.is_heartbeat) begin
        $error("is_heartbeat: expected %0b, got %0b", want.is_heartbeat, got.is_heartbeat);
        mismatches++;
      end
      if (got.framing_error !== want.framing_error) begin
        $error("framing_error: expected %0b, got %0b", want.framing_error, got.framing_error);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [15:0]        cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  lpd_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready = 1'b0;
  lpd_pkg::out_item_t out_data;

  packet_tracker tracker;
  int unsigned   idle_pct = 0;
  int unsigned   stall_pct = 0;
  int unsigned   hold_cycles = 0;
  int unsigned   sent_bytes = 0;
  logic [31:0]   sent_time = '0;

  length_prefix_deframer_heartbeat i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // A long hold-off takes precedence over the random stalls.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready   <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.take_byte(in_data);
      if (out_valid && out_ready) tracker.check_result(out_data);
    end
  end

  function automatic logic [31:0] rand_time();
    case ($urandom_range(15))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] value, input logic [31:0] stamp);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: value, now_seconds: stamp};
    sent_bytes++;
    do @(posedge clk); while (!in_ready);
  endtask

  // The word supplies the first eight payload bytes when use_word is set;
  // the stamp on the last byte becomes the block's last activity time.
  task automatic send_packet(input int unsigned len, input logic [63:0] word,
                             input bit use_word, input logic [31:0] last_stamp);
    send_byte(len[7:0], rand_time());
    send_byte(len[15:8], rand_time());
    for (int i = 0; i < len; i++) begin
      send_byte((use_word && i < 8) ? word[8*i +: 8] : 8'($urandom),
                (i == len - 1) ? last_stamp : rand_time());
    end
    sent_time = last_stamp;
  endtask

  task automatic random_packet(input logic [15:0] limit);
    int unsigned len;
    int unsigned cap;
    int unsigned flip;
    logic [63:0] word;
    if (limit >= 16'd8 && $urandom_range(3) == 0) begin
      word = {32'd0, sent_time} + 64'd1;
      // Some heartbeat candidates miss by a single bit.
      if ($urandom_range(3) == 0) begin
        flip       = $urandom_range(63);
        word[flip] = ~word[flip];
      end
      send_packet(8, word, 1'b1, rand_time());
    end else begin
      cap = (limit < 16'd24) ? limit : 24;
      if ($urandom_range(39) == 0) cap = (limit < 16'd300) ? limit : 300;
      len = $urandom_range(cap, 1);
      send_packet(len, '0, 1'b0, rand_time());
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tracker.set_limit(value);
  endtask

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [15:0]  limits[8];
    int unsigned  send_pcts[8];
    int unsigned  stall_pcts[8];
    int unsigned  start;
    int unsigned  len;
    logic [15:0]  lim;
    close_cause_t cause;

    tracker   = new();
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Heartbeat against the reset time, then one whose value carries past
    // 32 bits, a nine-byte packet that must not count, and byte extremes.
    send_packet(8, 64'd1, 1'b1, 32'hFFFF_FFFF);
    send_packet(8, 64'h1_0000_0000, 1'b1, 32'h0);
    send_packet(9, 64'd1, 1'b1, rand_time());
    send_packet(2, 64'h00FF, 1'b1, rand_time());

    limits = '{16'd1, 16'd65535, 16'($urandom_range(40, 2)), 16'd8,
               16'($urandom_range(65535, 1)), lpd_pkg::MAX_LEN_RST,
               16'($urandom_range(300, 9)), 16'($urandom_range(65535, 1))};
    send_pcts  = '{82, 0, 0, 9, 0, 82, 0, 9};
    stall_pcts = '{0, 0, 82, 9, 0, 0, 82, 9};

    for (int p = 0; p < 8; p++) begin
      wait_drained();
      write_limit(limits[p]);
      idle_pct  = send_pcts[p];
      stall_pct = stall_pcts[p];
      // Downstream holds off while requests keep coming, so the block backs up.
      if (p == 4) hold_cycles <= 300;
      start = sent_bytes;
      while (sent_bytes - start < 240) random_packet(limits[p]);
    end

    // Close the session once, then show that later bytes are ignored.
    wait_drained();
    cause = close_cause_t'($urandom_range(2));
    case (cause)
      CLOSE_ZERO_LEN: begin
        write_limit(16'($urandom_range(65535, 1)));
        send_byte(8'h00, rand_time());
        send_byte(8'h00, rand_time());
      end
      CLOSE_OVER_LIMIT: begin
        lim = 16'($urandom_range(65534, 1));
        write_limit(lim);
        len = $urandom_range(65535, lim + 1);
        send_byte(len[7:0], rand_time());
        send_byte(len[15:8], rand_time());
      end
      default: begin
        write_limit(16'd0);
        len = $urandom_range(65535, 1);
        send_byte(len[7:0], rand_time());
        send_byte(len[15:8], rand_time());
      end
    endcase
    repeat (20) send_byte(8'($urandom), rand_time());
    wait_drained();
    repeat (8) @(posedge clk);

    if (tracker.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
